// ===== design/bkw_pkg.sv =====
package bkw_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int LANE_STAGES  = 5;
  localparam int MERGE_STAGES = 4;
  localparam int NUM_STAGES   = LANE_STAGES + MERGE_STAGES;
  localparam int GRAD_SHIFT   = 46 - FRAC_BITS;

  localparam logic [31:0] Q30_THREE_QUARTERS = 32'd3 << 28;
  localparam logic [31:0] Q30_THREE_HALVES   = 32'd3 << 29;
  localparam logic [31:0] Q30_TWO            = 32'd1 << 31;
  localparam logic [31:0] Q30_TWO_THIRDS     = 32'd715827883;
  localparam logic [31:0] RECIP_THREE        = 32'hAAAAAAAB;

  localparam logic [23:0] INV_GRID_RESET = 24'd65536;

  typedef enum logic [0:0] {
    CFG_KERNEL_SELECT = 1'b0,
    CFG_INV_GRID_SIZE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] node_z;
    logic signed [31:0] particle_x;
    logic signed [31:0] particle_y;
    logic signed [31:0] particle_z;
  } in_t;

  typedef struct packed {
    logic [15:0]        weight;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
  } out_t;

  typedef struct packed {
    logic [30:0] k;
    logic [30:0] m;
    logic        neg;
  } lane_res_t;

endpackage

// ===== design/bkw_lane.sv =====
module bkw_lane (
  input  logic                               clk,
  input  logic [bkw_pkg::LANE_STAGES-1:0]    en,
  input  logic                               kernel_select,
  input  logic [23:0]                        inv_grid_size,
  input  logic signed [31:0]                 node,
  input  logic signed [31:0]                 particle,
  output bkw_pkg::lane_res_t                 res
);

  localparam int F = bkw_pkg::FRAC_BITS;
  localparam logic [40:0] QUAD_OUTER = 41'd3 << (F - 1);
  localparam logic [40:0] QUAD_INNER = 41'd1 << (F - 1);
  localparam logic [40:0] CUB_OUTER  = 41'd2 << F;
  localparam logic [40:0] CUB_INNER  = 41'd1 << F;

  // stage 0: offset magnitude and sign
  logic signed [32:0] d;
  logic [32:0]        mag0_r;
  logic               neg0_r;

  assign d = {particle[31], particle} - {node[31], node};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg0_r <= d[32];
      mag0_r <= d[32] ? 33'(-d) : 33'(d);
    end
  end

  // stage 1: scale to grid units, classify interval
  logic [56:0] prod1;
  logic [40:0] a1;
  logic [30:0] x1_r;
  logic        inner1_r, out1_r, neg1_r;

  assign prod1 = 57'(mag0_r) * 57'(inv_grid_size);
  assign a1    = prod1[56:16];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg1_r   <= neg0_r;
      x1_r     <= {a1[F:0], {(30 - F){1'b0}}};
      inner1_r <= kernel_select ? (a1 < CUB_INNER) : (a1 < QUAD_INNER);
      out1_r   <= kernel_select ? (a1 >= CUB_OUTER) : (a1 >= QUAD_OUTER);
    end
  end

  // stage 2: base and square
  logic [31:0] b_full;
  logic [30:0] base2;
  logic [61:0] sqp2;
  logic [30:0] base2_r, sq2_r, x2_r;
  logic        inner2_r, out2_r, neg2_r;

  always_comb begin
    if (inner1_r) begin
      b_full = {1'b0, x1_r};
    end else if (!kernel_select) begin
      b_full = bkw_pkg::Q30_THREE_HALVES - {1'b0, x1_r};
    end else begin
      b_full = bkw_pkg::Q30_TWO - {1'b0, x1_r};
    end
  end

  assign base2 = b_full[30:0];
  assign sqp2  = 62'(base2) * 62'(base2);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      base2_r  <= base2;
      sq2_r    <= sqp2[60:30];
      x2_r     <= x1_r;
      inner2_r <= inner1_r;
      out2_r   <= out1_r;
      neg2_r   <= neg1_r;
    end
  end

  // stage 3: cube
  logic [61:0] cbp3;
  logic [30:0] base3_r, sq3_r, x3_r, cube3_r;
  logic        inner3_r, out3_r, neg3_r;

  assign cbp3 = 62'(sq2_r) * 62'(base2_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      cube3_r  <= cbp3[60:30];
      base3_r  <= base2_r;
      sq3_r    <= sq2_r;
      x3_r     <= x2_r;
      inner3_r <= inner2_r;
      out3_r   <= out2_r;
      neg3_r   <= neg2_r;
    end
  end

  // stage 4: kernel value and derivative magnitude
  logic [31:0] two_x, t4, th4, k4, m4;
  logic [62:0] divp4;

  assign two_x = {x3_r, 1'b0};
  assign t4    = bkw_pkg::Q30_TWO_THIRDS + 32'(cube3_r >> 1);
  assign th4   = 32'((33'(sq3_r) * 33'd3) >> 1);
  assign divp4 = 63'(cube3_r) * 63'(bkw_pkg::RECIP_THREE);

  always_comb begin
    if (out3_r) begin
      k4 = '0;
      m4 = '0;
    end else if (!kernel_select) begin
      if (inner3_r) begin
        k4 = bkw_pkg::Q30_THREE_QUARTERS - 32'(sq3_r);
        m4 = two_x;
      end else begin
        k4 = 32'(sq3_r >> 1);
        m4 = 32'(base3_r);
      end
    end else begin
      if (inner3_r) begin
        k4 = (t4 > 32'(sq3_r)) ? t4 - 32'(sq3_r) : '0;
        m4 = (two_x > th4) ? two_x - th4 : '0;
      end else begin
        k4 = 32'(divp4[62:34]);
        m4 = 32'(sq3_r >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      res.k   <= k4[30:0];
      res.m   <= m4[30:0];
      res.neg <= neg3_r;
    end
  end

endmodule

// ===== design/bkw_merge.sv =====
module bkw_merge (
  input  logic                               clk,
  input  logic [bkw_pkg::MERGE_STAGES-1:0]   en,
  input  logic [23:0]                        inv_grid_size,
  input  bkw_pkg::lane_res_t                 lx,
  input  bkw_pkg::lane_res_t                 ly,
  input  bkw_pkg::lane_res_t                 lz,
  output bkw_pkg::out_t                      result
);

  // stage 0: first products
  logic [61:0] w1p, pap, pbp, pcp;
  logic [30:0] w1_r, pa1_r, pb1_r, pc1_r, kz1_r, ky1_r;
  logic [2:0]  neg1_r;

  assign w1p = 62'(lx.k) * 62'(ly.k);
  assign pap = 62'(lx.m) * 62'(ly.k);
  assign pbp = 62'(ly.m) * 62'(lx.k);
  assign pcp = 62'(lz.m) * 62'(lx.k);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      w1_r   <= w1p[60:30];
      pa1_r  <= pap[60:30];
      pb1_r  <= pbp[60:30];
      pc1_r  <= pcp[60:30];
      kz1_r  <= lz.k;
      ky1_r  <= ly.k;
      neg1_r <= {lz.neg, ly.neg, lx.neg};
    end
  end

  // stage 1: second products
  logic [61:0] w2p, gap, gbp, gcp;
  logic [30:0] w2_r, ga2_r, gb2_r, gc2_r;
  logic [2:0]  neg2_r;

  assign w2p = 62'(w1_r) * 62'(kz1_r);
  assign gap = 62'(pa1_r) * 62'(kz1_r);
  assign gbp = 62'(pb1_r) * 62'(kz1_r);
  assign gcp = 62'(pc1_r) * 62'(ky1_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      w2_r   <= w2p[60:30];
      ga2_r  <= gap[60:30];
      gb2_r  <= gbp[60:30];
      gc2_r  <= gcp[60:30];
      neg2_r <= neg1_r;
    end
  end

  // stage 2: scale by inverse grid size
  logic [54:0] sap, sbp, scp;
  logic [54:0] sa3_r, sb3_r, sc3_r;
  logic [15:0] wt3_r;
  logic [2:0]  neg3_r;

  assign sap = (55'(ga2_r) * 55'(inv_grid_size)) >> bkw_pkg::GRAD_SHIFT;
  assign sbp = (55'(gb2_r) * 55'(inv_grid_size)) >> bkw_pkg::GRAD_SHIFT;
  assign scp = (55'(gc2_r) * 55'(inv_grid_size)) >> bkw_pkg::GRAD_SHIFT;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sa3_r  <= sap;
      sb3_r  <= sbp;
      sc3_r  <= scp;
      wt3_r  <= w2_r[29:14];
      neg3_r <= neg2_r;
    end
  end

  // stage 3: sign and saturate
  function automatic logic [31:0] sat_grad(input logic [54:0] p, input logic neg);
    logic [31:0] r;
    if (p == '0) begin
      r = '0;
    end else if (neg) begin
      r = (p > 55'h7FFFFFFF) ? 32'h7FFFFFFF : p[31:0];
    end else begin
      r = (p > 55'h80000000) ? 32'h80000000 : 32'd0 - p[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en[3]) begin
      result.weight <= wt3_r;
      result.grad_x <= sat_grad(sa3_r, neg3_r[0]);
      result.grad_y <= sat_grad(sb3_r, neg3_r[1]);
      result.grad_z <= sat_grad(sc3_r, neg3_r[2]);
    end
  end

endmodule

// ===== design/bspline_kernel_weight_gradient_top.sv =====
// Pipeline: 5 per-axis lane stages, then 4 merge stages.
// Throughput: one request per cycle; each stage holds its request under output stall,
// and bubbles collapse so new requests enter while a result waits.
// Reset (rst_n low, synchronous): pipeline emptied, kernel_select = 0,
// inv_grid_size = 65536.
module bspline_kernel_weight_gradient_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bkw_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bkw_pkg::out_t     out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  bkw_pkg::cfg_idx_t cfg_index,
  input  logic [23:0]       cfg_data
);

  localparam int NS = bkw_pkg::NUM_STAGES;
  localparam int LS = bkw_pkg::LANE_STAGES;

  logic        ks_r;
  logic [23:0] inv_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r  <= 1'b0;
      inv_r <= bkw_pkg::INV_GRID_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bkw_pkg::CFG_KERNEL_SELECT: ks_r  <= cfg_data[0];
        bkw_pkg::CFG_INV_GRID_SIZE: inv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NS-1:0] v_r, v_nxt, load;

  always_comb begin
    load[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      load[i] = !v_r[i] || load[i+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (load[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int i = 1; i < NS; i++) begin
      if (load[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = load[0];
  assign out_valid = v_r[NS-1];

  bkw_pkg::lane_res_t lx, ly, lz;

  bkw_lane u_lane_x (
    .clk(clk), .en(load[LS-1:0]), .kernel_select(ks_r), .inv_grid_size(inv_r),
    .node(in_data.node_x), .particle(in_data.particle_x), .res(lx)
  );

  bkw_lane u_lane_y (
    .clk(clk), .en(load[LS-1:0]), .kernel_select(ks_r), .inv_grid_size(inv_r),
    .node(in_data.node_y), .particle(in_data.particle_y), .res(ly)
  );

  bkw_lane u_lane_z (
    .clk(clk), .en(load[LS-1:0]), .kernel_select(ks_r), .inv_grid_size(inv_r),
    .node(in_data.node_z), .particle(in_data.particle_z), .res(lz)
  );

  bkw_merge u_merge (
    .clk(clk), .en(load[NS-1:LS]), .inv_grid_size(inv_r),
    .lx(lx), .ly(ly), .lz(lz), .result(out_data)
  );

endmodule

// ===== design/bkw_checker.sv =====
module bkw_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input bkw_pkg::out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused while output is empty");

  a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.weight <= 16'd27648)
    else $error("weight above kernel peak");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

endmodule

bind bspline_kernel_weight_gradient_top bkw_checker u_bkw_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam longint CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  bkw_pkg::in_t       in_data;
  logic               out_valid;
  logic               out_ready;
  bkw_pkg::out_t      out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  bkw_pkg::cfg_idx_t  cfg_index;
  logic [23:0]        cfg_data;

  bspline_kernel_weight_gradient_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  class weight_scoreboard;
    bit            cubic;
    logic [23:0]   inv_grid;
    bkw_pkg::out_t pending[$];
    int            errors;

    function new();
      cubic = 0;
      inv_grid = bkw_pkg::INV_GRID_RESET;
      errors = 0;
    endfunction

    function void set_reg(bkw_pkg::cfg_idx_t idx, logic [23:0] v);
      if (idx == bkw_pkg::CFG_KERNEL_SELECT) cubic = v[0];
      else inv_grid = v;
    endfunction

    function automatic longint unsigned sqr30(longint unsigned x);
      return (x * x) >> 30;
    endfunction

    function automatic void axis_kernel(longint unsigned a, output longint unsigned k,
                                        output longint unsigned m);
      longint unsigned x, b, c, c3, t;
      k = 0;
      m = 0;
      x = a << (30 - bkw_pkg::FRAC_BITS);
      if (!cubic) begin
        if (a >= (64'd3 << (bkw_pkg::FRAC_BITS - 1))) return;
        if (a < (64'd1 << (bkw_pkg::FRAC_BITS - 1))) begin
          k = 64'(bkw_pkg::Q30_THREE_QUARTERS) - sqr30(x);
          m = 2 * x;
        end else begin
          b = 64'(bkw_pkg::Q30_THREE_HALVES) - x;
          k = sqr30(b) >> 1;
          m = b;
        end
      end else begin
        if (a >= (64'd2 << bkw_pkg::FRAC_BITS)) return;
        if (a < (64'd1 << bkw_pkg::FRAC_BITS)) begin
          c = sqr30(x);
          c3 = (c * x) >> 30;
          t = 64'(bkw_pkg::Q30_TWO_THIRDS) + (c3 >> 1);
          k = (t > c) ? t - c : 0;
          t = (3 * c) >> 1;
          m = (2 * x > t) ? 2 * x - t : 0;
        end else begin
          b = 64'(bkw_pkg::Q30_TWO) - x;
          c = sqr30(b);
          k = ((c * b) >> 30) / 6;
          m = c >> 1;
        end
      end
    endfunction

    function automatic logic [31:0] grad_component(longint unsigned m, longint unsigned k1,
                                                   longint unsigned k2, bit dneg);
      longint unsigned p;
      p = (m * k1) >> 30;
      p = (p * k2) >> 30;
      p = (p * inv_grid) >> bkw_pkg::GRAD_SHIFT;
      if (p == 0) return 32'd0;
      if (dneg) return (p > 64'h7FFFFFFF) ? 32'h7FFFFFFF : p[31:0];
      if (p > 64'h80000000) p = 64'h80000000;
      return 32'(-p);
    endfunction

    function void note_request(bkw_pkg::in_t r);
      longint          d[3];
      longint unsigned mag, k[3], m[3], w;
      bit              neg[3];
      bkw_pkg::out_t   e;
      d[0] = longint'(r.particle_x) - longint'(r.node_x);
      d[1] = longint'(r.particle_y) - longint'(r.node_y);
      d[2] = longint'(r.particle_z) - longint'(r.node_z);
      for (int i = 0; i < 3; i++) begin
        neg[i] = d[i] < 0;
        mag = neg[i] ? -d[i] : d[i];
        axis_kernel((mag * inv_grid) >> 16, k[i], m[i]);
      end
      w = (k[0] * k[1]) >> 30;
      w = (w * k[2]) >> 30;
      e.weight = w[29:14];
      e.grad_x = grad_component(m[0], k[1], k[2], neg[0]);
      e.grad_y = grad_component(m[1], k[0], k[2], neg[1]);
      e.grad_z = grad_component(m[2], k[0], k[1], neg[2]);
      pending.push_back(e);
    endfunction

    function void check_result(bkw_pkg::out_t got);
      bkw_pkg::out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.weight !== e.weight) begin
        $display("%0t: weight exp %h got %h", $time, e.weight, got.weight);
        errors++;
      end
      if (got.grad_x !== e.grad_x) begin
        $display("%0t: grad_x exp %h got %h", $time, e.grad_x, got.grad_x);
        errors++;
      end
      if (got.grad_y !== e.grad_y) begin
        $display("%0t: grad_y exp %h got %h", $time, e.grad_y, got.grad_y);
        errors++;
      end
      if (got.grad_z !== e.grad_z) begin
        $display("%0t: grad_z exp %h got %h", $time, e.grad_z, got.grad_z);
        errors++;
      end
    endfunction
  endclass

  weight_scoreboard sb;
  longint cycles;
  bit     hold_off;
  bit     draining;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial sb = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** bspline_kernel_weight_gradient_top: FAILED **");
      $finish;
    end
    if (rst_n && in_valid && in_ready) sb.note_request(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (rst_n && cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, long hold-off on request
  initial begin
    int g;
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (60) @(negedge clk);
        hold_off = 0;
      end
      g = draining ? 0 : gap_len();
      if (g == 0 || $urandom_range(0, 3) == 0) begin
        out_ready <= 1;
        @(negedge clk);
      end else begin
        out_ready <= 0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // valid stays up between back-to-back requests; wait_idle drops it
  task automatic send_request(bkw_pkg::in_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(bkw_pkg::cfg_idx_t idx, logic [23:0] v);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    draining = 1;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (bkw_pkg::NUM_STAGES + 4) @(negedge clk);
    draining = 0;
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      default: return $urandom();
    endcase
  endfunction

  // particle near the node, so most requests land inside the kernel support
  function automatic bkw_pkg::in_t near_request(int spread);
    bkw_pkg::in_t r;
    r.node_x = rnd_word();
    r.node_y = rnd_word();
    r.node_z = rnd_word();
    r.particle_x = r.node_x + $signed($urandom_range(0, 2 * spread)) - spread;
    r.particle_y = r.node_y + $signed($urandom_range(0, 2 * spread)) - spread;
    r.particle_z = r.node_z + $signed($urandom_range(0, 2 * spread)) - spread;
    return r;
  endfunction

  task automatic directed_set();
    bkw_pkg::in_t r;
    r = '0;
    send_request(r);
    r.particle_x = 32'sh00008000; send_request(r);
    r.particle_x = -32'sh00008000; send_request(r);
    r.particle_y = 32'sh00010000; send_request(r);
    r.particle_z = -32'sh00018000; send_request(r);
    r = '0; r.particle_x = 32'sh00020000; send_request(r);
    r = '0; r.particle_z = -32'sh0001FFFF; send_request(r);
    r = '0; r.particle_y = 32'sh00004000; r.particle_z = 32'sh0000C000; send_request(r);
    r.node_x = 32'h80000000; r.particle_x = 32'h7FFFFFFF; send_request(r);
    r.node_x = 32'h7FFFFFFF; r.particle_x = 32'h80000000; send_request(r);
    r = '1; send_request(r);
    r = near_request(32'h00008000); send_request(r);
  endtask

  localparam logic [23:0] INV_CHOICES [6] = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd32768,
                                              24'd262144, 24'd0};

  initial begin
    bkw_pkg::in_t r;
    int  n;
    rst_n = 0;
    cycles = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = bkw_pkg::CFG_KERNEL_SELECT;
    cfg_data = '0;
    hold_off = 0;
    draining = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    directed_set();
    wait_idle();
    write_reg(bkw_pkg::CFG_KERNEL_SELECT, 24'd1);
    directed_set();
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      logic [23:0] inv;
      inv = (ph < 6) ? INV_CHOICES[ph] : 24'($urandom_range(1, 24'hFFFFFF));
      write_reg(bkw_pkg::CFG_KERNEL_SELECT, 24'(ph % 2));
      write_reg(bkw_pkg::CFG_INV_GRID_SIZE, inv);
      if (ph == 3) hold_off = 1;
      for (n = 0; n < 125; n++) begin
        case ($urandom_range(0, 9))
          0: begin
            r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
          end
          1: r = near_request(32'h00000100);
          2: r = near_request(32'h01000000);
          default: r = near_request(inv > 24'd262144 ? 32'h00004000 : 32'h00028000);
        endcase
        send_request(r);
      end
      wait_idle();
    end
    write_reg(bkw_pkg::CFG_INV_GRID_SIZE, bkw_pkg::INV_GRID_RESET);
    wait_idle();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** bspline_kernel_weight_gradient_top: PASSED **");
    end else begin
      $display("** bspline_kernel_weight_gradient_top: FAILED **");
    end
    $finish;
  end

endmodule
